FILE: rtl/hcbd_pkg.sv
package hcbd_pkg;

  localparam int SIZE_BITS = 32;
  localparam int LINE_BITS = 16;

  localparam logic [LINE_BITS-1:0] MAX_LINE_RESET = 16'd8192;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SEMI  = 8'h3b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;

  localparam logic [2:0] PH_LINE  = 3'd0;
  localparam logic [2:0] PH_DATA  = 3'd1;
  localparam logic [2:0] PH_SKIP1 = 3'd2;
  localparam logic [2:0] PH_SKIP2 = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  localparam logic [2:0] K_BYTE  = 3'd0;
  localparam logic [2:0] K_DONE  = 3'd1;
  localparam logic [2:0] K_BLANK = 3'd2;
  localparam logic [2:0] K_NEG   = 3'd3;
  localparam logic [2:0] K_LONG  = 3'd4;
  localparam logic [2:0] K_TRUNC = 3'd5;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] body_byte;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] chunk;
    logic [LINE_BITS-1:0] length;
    logic                 saw_nonblank;
    logic                 digits_ended;
    logic                 in_extension;
    logic                 size_negative;
  } line_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: rtl/http_chunked_body_decoder.sv
// Decodes an HTTP/1.1 chunked body: each word is one received byte or an end-of-stream
// mark, and each word gives at most one result (a payload byte or a final status).
// A word is taken each cycle that byte_ready is high; its result is available in the next
// cycle from a two-entry output queue, and byte_ready drops only while it holds two unread
// results. The size-line limit is written through the cfg port, which is always ready.
module http_chunked_body_decoder
  import hcbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  in_item_t             byte_item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output out_item_t            result_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LINE_BITS-1:0] cfg_data
);

  logic [LINE_BITS-1:0] max_size_line;
  logic [2:0]           phase;
  logic [2:0]           phase_next;
  line_state_t          line;
  line_state_t          line_next;
  logic                 cr_pending;
  logic                 cr_pending_next;

  line_state_t          cr_state;
  logic                 cr_long;
  line_state_t          mid_state;
  line_state_t          byte_state;
  logic                 byte_long;
  line_state_t          cleared;

  logic                 accept;
  logic                 res_valid;
  out_item_t            res_item;
  queue_status_t        q_status;
  logic [7:0]           ch;
  logic [SIZE_BITS-1:0] remaining_dec;

  assign accept    = byte_valid && byte_ready;
  assign cfg_ready = 1'b1;
  assign ch        = byte_item.stream_byte;

  always_comb begin
    cleared = '0;
  end

  hcbd_line_step u_cr_step (
    .cur      (line),
    .ch       (CHAR_CR),
    .max_len  (max_size_line),
    .nxt      (cr_state),
    .too_long (cr_long)
  );

  assign mid_state = cr_pending ? cr_state : line;

  hcbd_line_step u_byte_step (
    .cur      (mid_state),
    .ch       (ch),
    .max_len  (max_size_line),
    .nxt      (byte_state),
    .too_long (byte_long)
  );

  assign remaining_dec = line.chunk - 1'b1;

  always_comb begin
    phase_next      = phase;
    line_next       = line;
    cr_pending_next = cr_pending;
    res_valid       = 1'b0;
    res_item        = '0;
    if (phase > PH_SKIP2) begin
      phase_next = PH_DONE;
    end else if (byte_item.end_of_stream) begin
      phase_next      = PH_DONE;
      line_next       = cleared;
      cr_pending_next = 1'b0;
      res_valid       = 1'b1;
      res_item.kind   = K_TRUNC;
    end else begin
      unique case (phase)
        PH_DATA: begin
          line_next.chunk    = remaining_dec;
          res_valid          = 1'b1;
          res_item.kind      = K_BYTE;
          res_item.body_byte = ch;
          if (remaining_dec == '0) begin
            phase_next = PH_SKIP1;
          end
        end
        PH_SKIP1: begin
          phase_next = PH_SKIP2;
        end
        PH_SKIP2: begin
          phase_next      = PH_LINE;
          line_next       = cleared;
          cr_pending_next = 1'b0;
        end
        default: begin
          if (cr_pending && ch == CHAR_LF) begin
            cr_pending_next = 1'b0;
            line_next       = cleared;
            if (!line.saw_nonblank) begin
              phase_next    = PH_DONE;
              res_valid     = 1'b1;
              res_item.kind = K_BLANK;
            end else if (line.size_negative && line.chunk != '0) begin
              phase_next    = PH_DONE;
              res_valid     = 1'b1;
              res_item.kind = K_NEG;
            end else if (line.chunk == '0) begin
              phase_next    = PH_DONE;
              res_valid     = 1'b1;
              res_item.kind = K_DONE;
            end else begin
              phase_next      = PH_DATA;
              line_next.chunk = line.chunk;
            end
          end else if (cr_pending && cr_long) begin
            phase_next      = PH_DONE;
            line_next       = cleared;
            cr_pending_next = 1'b0;
            res_valid       = 1'b1;
            res_item.kind   = K_LONG;
          end else if (ch == CHAR_CR) begin
            line_next       = mid_state;
            cr_pending_next = 1'b1;
          end else if (byte_long) begin
            phase_next      = PH_DONE;
            line_next       = cleared;
            cr_pending_next = 1'b0;
            res_valid       = 1'b1;
            res_item.kind   = K_LONG;
          end else begin
            line_next       = byte_state;
            cr_pending_next = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size_line <= MAX_LINE_RESET;
      phase         <= PH_LINE;
      line          <= '0;
      cr_pending    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_size_line <= cfg_data;
      end
      if (accept) begin
        phase      <= phase_next;
        line       <= line_next;
        cr_pending <= cr_pending_next;
      end
    end
  end

  hcbd_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_item (res_item),
    .pop       (result_ready),
    .head_item (result_item),
    .status    (q_status)
  );

  assign byte_ready   = !q_status.full;
  assign result_valid = !q_status.empty;

`ifndef SYNTH
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_DONE) |-> !res_valid)
    else $error("Result produced after the body ended.");

  a_byte_in_data: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && res_item.kind == K_BYTE) |-> (phase == PH_DATA))
    else $error("Payload byte produced outside chunk data.");

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (line.chunk != '0))
    else $error("Chunk data phase with nothing left to pass.");

  a_queue_result: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid) |=> result_valid)
    else $error("Result missing from the output queue.");
`endif

endmodule

FILE: rtl/hcbd_line_step.sv
module hcbd_line_step
  import hcbd_pkg::*;
(
  input  line_state_t          cur,
  input  logic [7:0]           ch,
  input  logic [LINE_BITS-1:0] max_len,
  output line_state_t          nxt,
  output logic                 too_long
);

  logic       is_blank;
  logic       is_hex;
  logic [3:0] digit;
  logic       take_digit;

  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      digit = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      digit = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      digit = 4'(ch - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_blank = (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_CR) || (ch == CHAR_LF);

  always_comb begin
    nxt        = cur;
    too_long   = 1'b0;
    take_digit = 1'b0;
    if (cur.length >= max_len) begin
      too_long = 1'b1;
    end else begin
      nxt.length = cur.length + 1'b1;
      if (!cur.in_extension) begin
        if (ch == CHAR_SEMI) begin
          nxt.in_extension = 1'b1;
        end else if (!cur.saw_nonblank) begin
          if (!is_blank) begin
            nxt.saw_nonblank = 1'b1;
            if (ch == CHAR_MINUS) begin
              nxt.size_negative = 1'b1;
            end else if (ch != CHAR_PLUS) begin
              take_digit = 1'b1;
            end
          end
        end else if (!cur.digits_ended) begin
          take_digit = 1'b1;
        end
      end
      if (take_digit) begin
        if (!is_hex) begin
          nxt.digits_ended = 1'b1;
        end else if (cur.chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
          nxt.chunk = '1;
        end else begin
          nxt.chunk = {cur.chunk[SIZE_BITS-5:0], digit};
        end
      end
    end
  end

endmodule

FILE: rtl/hcbd_out_queue.sv
module hcbd_out_queue
  import hcbd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  out_item_t     push_item,
  input  logic          pop,
  output out_item_t     head_item,
  output queue_status_t status
);

  out_item_t   head;
  out_item_t   second;
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        do_pop;
  logic [1:0]  slot;

  assign do_pop     = pop && (count != 2'd0);
  assign slot       = count - {1'b0, do_pop};
  assign count_next = count + {1'b0, push} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && count == 2'd2) begin
      head <= second;
    end
    if (push && slot == 2'd0) begin
      head <= push_item;
    end
    if (push && slot == 2'd1) begin
      second <= push_item;
    end
  end

  assign head_item    = head;
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

endmodule

FILE: sim/tb.sv
module tb;
  import hcbd_pkg::*;

  typedef logic [7:0] text_t[$];

  class body_scoreboard;
    logic [LINE_BITS-1:0] limit = MAX_LINE_RESET;
    logic [2:0] phase = PH_LINE;
    logic [SIZE_BITS-1:0] chunk_left = '0;
    logic [LINE_BITS-1:0] line_len = '0;
    bit cr_seen;
    bit nonblank;
    bit digits_over;
    bit in_ext;
    bit negative;
    out_item_t expected_q[$];
    int errors;

    function void set_limit(logic [LINE_BITS-1:0] v);
      limit = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void clear_line();
      chunk_left = '0;
      line_len = '0;
      cr_seen = 0;
      nonblank = 0;
      digits_over = 0;
      in_ext = 0;
      negative = 0;
    endfunction

    function int hex_digit(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
    endfunction

    function bit line_byte(logic [7:0] c);
      int d;
      if ({1'b0, line_len} + 17'd1 > {1'b0, limit}) return 0;
      line_len++;
      if (in_ext) return 1;
      if (c == CHAR_SEMI) begin
        in_ext = 1;
        return 1;
      end
      if (!nonblank) begin
        if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF) return 1;
        nonblank = 1;
        if (c == CHAR_MINUS) begin
          negative = 1;
          return 1;
        end
        if (c == CHAR_PLUS) return 1;
      end else if (digits_over) begin
        return 1;
      end
      d = hex_digit(c);
      if (d < 0) begin
        digits_over = 1;
        return 1;
      end
      if (chunk_left > ({SIZE_BITS{1'b1}} >> 4)) chunk_left = '1;
      else chunk_left = (chunk_left << 4) | SIZE_BITS'(d);
      return 1;
    endfunction

    function void end_body(logic [2:0] k);
      out_item_t r;
      r.kind = k;
      r.body_byte = 8'h00;
      phase = PH_DONE;
      clear_line();
      expected_q = {expected_q, r};
    endfunction

    function void note_word(in_item_t w);
      logic [7:0] c;
      logic [SIZE_BITS-1:0] n;
      out_item_t r;
      c = w.stream_byte;
      if (phase > PH_SKIP2) begin
        phase = PH_DONE;
        return;
      end
      if (w.end_of_stream) begin
        end_body(K_TRUNC);
        return;
      end
      case (phase)
        PH_DATA: begin
          chunk_left--;
          if (chunk_left == 0) phase = PH_SKIP1;
          r.kind = K_BYTE;
          r.body_byte = c;
          expected_q = {expected_q, r};
          return;
        end
        PH_SKIP1: begin
          phase = PH_SKIP2;
          return;
        end
        PH_SKIP2: begin
          phase = PH_LINE;
          clear_line();
          return;
        end
        default: ;
      endcase
      if (cr_seen && c == CHAR_LF) begin
        if (!nonblank) end_body(K_BLANK);
        else if (negative && chunk_left != 0) end_body(K_NEG);
        else if (chunk_left == 0) end_body(K_DONE);
        else begin
          n = chunk_left;
          clear_line();
          chunk_left = n;
          phase = PH_DATA;
        end
        return;
      end
      if (cr_seen) begin
        cr_seen = 0;
        if (!line_byte(CHAR_CR)) begin
          end_body(K_LONG);
          return;
        end
      end
      if (c == CHAR_CR) begin
        cr_seen = 1;
        return;
      end
      if (!line_byte(c)) end_body(K_LONG);
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: kind=%0d byte=%h with nothing expected",
                   got.kind, got.body_byte);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.body_byte !== want.body_byte) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected kind=%0d byte=%h, got kind=%0d byte=%h",
                   want.kind, want.body_byte, got.kind, got.body_byte);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic byte_valid;
  logic byte_ready;
  in_item_t byte_item;
  logic result_valid;
  logic result_ready;
  out_item_t result_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [LINE_BITS-1:0] cfg_data;

  body_scoreboard sb;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int words_sent = 0;

  http_chunked_body_decoder u_top (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .byte_item(byte_item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_item(result_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_word(logic [7:0] b, bit eos);
    in_item_t w;
    w.stream_byte = b;
    w.end_of_stream = eos;
    while (!steady && $urandom_range(99) < 14) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= w;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sb.note_word(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(text_t t);
    foreach (t[i]) send_word(t[i], 1'b0);
  endtask

  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [LINE_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_limit(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_byte(ref text_t t, input logic [7:0] b);
    t = {t, b};
  endfunction

  function automatic logic [7:0] hex_char(int d, bit upper);
    if (d < 10) return 8'(8'h30 + d);
    return 8'((upper ? 8'h41 : 8'h61) + d - 10);
  endfunction

  function automatic void push_hex(ref text_t t, input logic [SIZE_BITS-1:0] n);
    bit started;
    started = 0;
    for (int shift = SIZE_BITS - 4; shift >= 0; shift -= 4) begin
      if (n[shift +: 4] != 0 || started || shift == 0) begin
        started = 1;
        add_byte(t, hex_char(n[shift +: 4], 1'($urandom_range(1))));
      end
    end
  endfunction

  // A CR directly followed by LF would close the size line early.
  function automatic void push_junk(ref text_t t, input int count);
    logic [7:0] b;
    repeat (count) begin
      b = 8'($urandom_range(255));
      if (b == CHAR_LF && t.size() > 0 && t[$] == CHAR_CR) b = CHAR_TAB;
      add_byte(t, b);
    end
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 64);
    return $urandom_range(65, 300);
  endfunction

  task automatic send_chunk(int n);
    text_t t;
    logic [7:0] b;
    if (sb.limit < 8) n = (n - 1) % 15 + 1;
    if (sb.limit >= 24 && $urandom_range(3) != 0) begin
      repeat ($urandom_range(3)) begin
        case ($urandom_range(3))
          0: b = CHAR_SPACE;
          1: b = CHAR_TAB;
          2: b = CHAR_LF;
          default: b = CHAR_CR;
        endcase
        if (b == CHAR_LF && t.size() > 0 && t[$] == CHAR_CR) b = CHAR_SPACE;
        add_byte(t, b);
      end
      if ($urandom_range(3) == 0) add_byte(t, CHAR_PLUS);
      repeat ($urandom_range(2)) add_byte(t, 8'h30);
      push_hex(t, n);
      case ($urandom_range(4))
        1: repeat ($urandom_range(1, 3)) add_byte(t, $urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
        2: begin
          add_byte(t, CHAR_SEMI);
          push_junk(t, $urandom_range(6));
        end
        3: begin
          add_byte(t, CHAR_CR);
          add_byte(t, 8'($urandom_range(8'h67, 8'h7a)));
          push_junk(t, $urandom_range(3));
        end
        4: begin
          add_byte(t, 8'($urandom_range(8'h67, 8'h7a)));
          push_junk(t, $urandom_range(4));
        end
        default: ;
      endcase
    end
    if (t.size() > sb.limit) t.delete();
    if (t.size() == 0) push_hex(t, n);
    add_byte(t, CHAR_CR);
    add_byte(t, CHAR_LF);
    send_text(t);
    repeat (n) send_word(8'($urandom_range(255)), 1'b0);
    send_word($urandom_range(3) == 0 ? 8'($urandom_range(255)) : CHAR_CR, 1'b0);
    send_word($urandom_range(3) == 0 ? 8'($urandom_range(255)) : CHAR_LF, 1'b0);
  endtask

  task automatic run_ending();
    text_t t;
    int way;
    int sub;
    way = $urandom_range(5);
    wait_idle();
    if (way == 4) write_limit(LINE_BITS'($urandom_range(1, 12)));
    else write_limit(LINE_BITS'($urandom_range(64, 65535)));
    if (way < 5) begin
      case (way)
        0: begin
          repeat ($urandom_range(2)) add_byte(t, CHAR_SPACE);
          repeat ($urandom_range(1, 3)) add_byte(t, 8'h30);
          if ($urandom_range(1)) begin
            add_byte(t, CHAR_SEMI);
            push_junk(t, 3);
          end
        end
        1: case ($urandom_range(3))
          0: add_byte(t, CHAR_PLUS);
          1: add_byte(t, CHAR_MINUS);
          2: begin
            add_byte(t, CHAR_MINUS);
            add_byte(t, 8'h30);
          end
          default: add_byte(t, 8'h71);
        endcase
        2: case ($urandom_range(2))
          1: begin
            add_byte(t, CHAR_SPACE);
            add_byte(t, CHAR_TAB);
          end
          2: begin
            add_byte(t, CHAR_SEMI);
            push_junk(t, 2);
          end
          default: ;
        endcase
        3: begin
          add_byte(t, CHAR_MINUS);
          if ($urandom_range(1)) repeat (12) add_byte(t, 8'h46);
          else push_hex(t, $urandom_range(1, 4095));
        end
        default: repeat (sb.limit + 2) add_byte(t, 8'($urandom_range(8'h20, 8'h7e)));
      endcase
      add_byte(t, CHAR_CR);
      add_byte(t, CHAR_LF);
      send_text(t);
    end else begin
      sub = $urandom_range(4);
      case (sub)
        0: begin
          add_byte(t, 8'h31);
          if ($urandom_range(1)) add_byte(t, CHAR_CR);
          send_text(t);
        end
        1: begin
          push_hex(t, 10);
          add_byte(t, CHAR_CR);
          add_byte(t, CHAR_LF);
          send_text(t);
          repeat ($urandom_range(9)) send_word(8'($urandom_range(255)), 1'b0);
        end
        2: begin
          // The size saturates, so the chunk can only end by the connection closing.
          repeat (10) add_byte(t, 8'h66);
          add_byte(t, CHAR_CR);
          add_byte(t, CHAR_LF);
          send_text(t);
          repeat (5) send_word(8'($urandom_range(255)), 1'b0);
        end
        default: begin
          push_hex(t, 3);
          add_byte(t, CHAR_CR);
          add_byte(t, CHAR_LF);
          send_text(t);
          repeat (3) send_word(8'($urandom_range(255)), 1'b0);
          if (sub == 3) send_word(CHAR_CR, 1'b0);
        end
      endcase
      send_word(8'($urandom_range(255)), 1'b1);
    end
    repeat (20) send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 100;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= steady || ($urandom_range(99) >= 14);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check(result_item);
  end

  initial begin
    text_t t;
    int p;
    int start;
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sb = new;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    t = '{CHAR_TAB, CHAR_PLUS, 8'h31, CHAR_SEMI, 8'h65, CHAR_CR, CHAR_LF, 8'hff,
          CHAR_CR, CHAR_LF,
          8'h32, CHAR_CR, 8'h71, CHAR_CR, CHAR_LF, 8'h00, 8'h80, 8'h78, 8'h79};
    send_text(t);

    p = 0;
    while (words_sent < 780) begin
      wait_idle();
      case (p)
        0: write_limit(16'hffff);
        1: write_limit(16'd1);
        2: write_limit(MAX_LINE_RESET);
        3: write_limit(LINE_BITS'($urandom_range(2, 40)));
        default: write_limit(LINE_BITS'($urandom_range(1, 65535)));
      endcase
      steady = (p == 2);
      start = words_sent;
      if (p == 0) begin
        hold_req = 1'b1;
        send_chunk(200);
      end
      while (words_sent - start < 150) send_chunk(pick_size());
      p++;
    end
    steady = 1'b0;
    run_ending();
    byte_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
